// ----- hw/rtl/bxavg_pkg.sv -----
// ----------------------------------------------------------------------------
// bxavg_pkg
// Shared types, constants and the block-average helper for the box
// average downscaler.
// ----------------------------------------------------------------------------
package bxavg_pkg;

  // Register indexes on the configuration port
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgSrcWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSrcHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgScale     = 2'd2;
  localparam int unsigned CfgDataW = 11;

  // Register reset values
  localparam logic [10:0] RstSrcWidth  = 11'd28;
  localparam logic [10:0] RstSrcHeight = 11'd28;
  localparam logic [3:0]  RstScale     = 4'd2;

  // Row geometry is fixed
  localparam int unsigned MaxHeight = 1024;
  localparam int unsigned HW        = 11;  // holds 1..MaxHeight
  localparam int unsigned RW        = 10;  // holds 0..MaxHeight-1

  // Partial sums and block area (area covers scales up to 16)
  localparam int unsigned SumW = 18;
  localparam int unsigned SqW  = 9;
  localparam int unsigned PixW = 8;

  // Reciprocal of the block area, scaled by 2^RecipK and rounded up; exact
  // for every sum below 256 areas
  localparam int unsigned RecipK = 24;
  localparam int unsigned RecipW = 25;
  localparam int unsigned QuoW   = 16;
  localparam int unsigned ProdW  = QuoW + RecipW;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_WIDTH,
    SEQ_HEIGHT,
    SEQ_ROW
  } seq_e;

  // One accepted pixel that touches the column-sum store
  typedef struct packed {
    logic [PixW-1:0] pix;
    logic            first;
    logic            emit;
    logic            row_end;
    logic            image_end;
    logic [SqW-1:0]  sq;
  } item_t;

  function automatic logic [RecipW-1:0] area_recip(logic [SqW-1:0] sq);
    logic [RecipW-1:0] r;
    case (sq)
      9'd1:    r = 25'd16777216;
      9'd4:    r = 25'd4194304;
      9'd9:    r = 25'd1864136;
      9'd16:   r = 25'd1048576;
      9'd25:   r = 25'd671089;
      9'd36:   r = 25'd466034;
      9'd49:   r = 25'd342393;
      9'd64:   r = 25'd262144;
      9'd81:   r = 25'd207127;
      9'd100:  r = 25'd167773;
      9'd121:  r = 25'd138655;
      9'd144:  r = 25'd116509;
      9'd169:  r = 25'd99274;
      9'd196:  r = 25'd85599;
      9'd225:  r = 25'd74566;
      9'd256:  r = 25'd65536;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Truncated sum / area, saturated to 255; the quotient has eight bits
  function automatic logic [PixW-1:0] block_avg(logic [SumW-1:0] sum,
                                                logic [SqW-1:0]  sq);
    logic [ProdW-1:0] prod;
    logic [PixW-1:0]  q;
    prod = ProdW'(sum[QuoW-1:0]) * ProdW'(area_recip(sq));
    if (sum >= (SumW'(sq) << PixW)) begin
      q = '1;
    end else begin
      q = prod[RecipK +: PixW];
    end
    return q;
  endfunction

endpackage

// ----- hw/rtl/bxavg_ram.sv -----
// ----------------------------------------------------------------------------
// bxavg_ram
// Single-port-write, single-port-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module bxavg_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned DataW = 18,
  parameter int unsigned AddrW = 10
) (
  input  logic             clk_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/bxavg_div.sv -----
// ----------------------------------------------------------------------------
// bxavg_div
// Restoring divider, one quotient bit per cycle. A start pulse restarts it.
// ----------------------------------------------------------------------------
module bxavg_div #(
  parameter int unsigned DW = 11,
  parameter int unsigned SW = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [SW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o,
  output logic [SW-1:0] remainder_o
);

  localparam int unsigned CntW = $clog2(DW + 1);

  logic [DW-1:0]   dvd_q, dvd_d;
  logic [SW-1:0]   rem_q, rem_d;
  logic [SW-1:0]   dsr_q, dsr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [SW:0]     trial;
  logic [SW:0]     diff;

  assign trial = {rem_q, dvd_q[DW-1]};
  assign diff  = trial - {1'b0, dsr_q};

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      cnt_d  = CntW'(DW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift the quotient bit in where the dividend bit leaves
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = diff[SW-1:0];
        dvd_d = {dvd_q[DW-2:0], 1'b1};
      end else begin
        rem_d = trial[SW-1:0];
        dvd_d = {dvd_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = dvd_q;
  assign remainder_o = rem_q;

endmodule

// ----- hw/rtl/bxavg_accum.sv -----
// ----------------------------------------------------------------------------
// bxavg_accum
// Read-modify-write of the column-sum store with write forwarding, and the
// output register that turns a finished block sum into an average.
// ----------------------------------------------------------------------------
module bxavg_accum #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  input  bxavg_pkg::item_t              req_i,
  input  logic [AddrW-1:0]              idx_i,
  output logic                          hold_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bxavg_pkg::PixW-1:0]    pixel_out_o,
  output logic                          row_end_o,
  output logic                          image_end_o
);

  logic                          s1_valid_q;
  bxavg_pkg::item_t              s1_q;
  logic [AddrW-1:0]              s1_idx_q;
  logic                          fwd_q;
  logic [bxavg_pkg::SumW-1:0]    fwd_sum_q;
  logic [bxavg_pkg::SumW-1:0]    rdata;
  logic [bxavg_pkg::SumW-1:0]    base;
  logic [bxavg_pkg::SumW-1:0]    sum;
  logic                          s1_adv;
  logic                          out_load;
  logic                          out_valid_q, out_valid_d;
  logic [bxavg_pkg::SumW-1:0]    out_sum_q;
  logic [bxavg_pkg::SqW-1:0]     out_sq_q;
  logic                          out_re_q;
  logic                          out_ie_q;

  bxavg_ram #(
    .Depth (Depth),
    .DataW (bxavg_pkg::SumW),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .re_i    (req_valid_i),
    .raddr_i (idx_i),
    .rdata_o (rdata),
    .we_i    (s1_adv),
    .waddr_i (s1_idx_q),
    .wdata_i (sum)
  );

  // the first pixel of a block starts the sum afresh
  assign base = fwd_q ? fwd_sum_q : rdata;
  assign sum  = s1_q.first ? bxavg_pkg::SumW'(s1_q.pix)
                           : base + bxavg_pkg::SumW'(s1_q.pix);

  // hold a finished block while the output beat is still stalled
  assign hold_o   = s1_valid_q && s1_q.emit && out_valid_q && out_stall_i;
  assign s1_adv   = s1_valid_q && !hold_o;
  assign out_load = s1_adv && s1_q.emit;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (req_valid_i) begin
        s1_valid_q <= 1'b1;
        fwd_q      <= s1_adv && (s1_idx_q == idx_i);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i) begin
      s1_q      <= req_i;
      s1_idx_q  <= idx_i;
      fwd_sum_q <= sum;
    end
    if (out_load) begin
      out_sum_q <= sum;
      out_sq_q  <= s1_q.sq;
      out_re_q  <= s1_q.row_end;
      out_ie_q  <= s1_q.image_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = bxavg_pkg::block_avg(out_sum_q, out_sq_q);
  assign row_end_o   = out_re_q;
  assign image_end_o = out_ie_q;

endmodule

// ----- hw/rtl/box_average_downscale_core.sv -----
// ----------------------------------------------------------------------------
// box_average_downscale_core
// Averages each square block of source pixels into one output pixel, with
// row and image end flags. Per-column partial sums live in one RAM.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   in      | input     | in_valid_i/in_stall_o  | pixel_in_i
//   out     | output    | out_valid_o/out_stall_i| pixel_out_o, row_end_o,
//           |           |                      | image_end_o
//   cfg     | input     | cfg_we_i             | cfg_index_i, cfg_wdata_i
//
// One pixel a cycle while neither busy nor stalled: the sum RAM is read on
// acceptance and written back when its stage advances, with the write forwarded
// to a following read of the same column. After reset and after every register
// write the block derives output width, height and output row with a bit-serial
// divider in three passes, in_stall_o held high meanwhile.
// A stalled output beat holds the finished block and, through it, the input.
// ----------------------------------------------------------------------------
module box_average_downscale_core #(
  parameter int unsigned MaxWidth = 1024,
  parameter int unsigned MaxScale = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [7:0]                       pixel_in_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [7:0]                       pixel_out_o,
  output logic                             row_end_o,
  output logic                             image_end_o,
  input  logic                             cfg_we_i,
  input  logic [bxavg_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [bxavg_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  localparam int unsigned CW = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int unsigned WW = $clog2(MaxWidth + 1);
  localparam int unsigned SW = $clog2(MaxScale + 1);
  localparam int unsigned BW = (MaxScale > 1) ? $clog2(MaxScale) : 1;
  localparam int unsigned HW = bxavg_pkg::HW;
  localparam int unsigned RW = bxavg_pkg::RW;
  localparam int unsigned DW = (WW > HW) ? WW : HW;

  // registers
  logic [10:0] src_width_q;
  logic [10:0] src_height_q;
  logic [3:0]  scale_q;

  // clamped geometry
  logic [WW-1:0]               w_c;
  logic [HW-1:0]               h_c;
  logic [SW-1:0]               s_c;
  logic [bxavg_pkg::SqW-1:0]   sq;

  // derived geometry
  logic [WW-1:0] new_w_q;
  logic [HW-1:0] new_h_q;

  // position counters
  logic [CW-1:0] src_col_q;
  logic [RW-1:0] src_row_q;
  logic [BW-1:0] col_blk_q;
  logic [BW-1:0] row_blk_q;
  logic [CW-1:0] out_col_q;
  logic [RW-1:0] out_row_q;
  logic [BW-1:0] row_rem_q;

  // sequencer
  bxavg_pkg::seq_e seq_q, seq_d;
  logic            start_q, start_d;
  logic            cap_w, cap_h, cap_r;
  logic            busy;

  logic          div_done;
  logic [DW-1:0] div_dvd;
  logic [DW-1:0] div_quo;
  logic [SW-1:0] div_rem;

  logic             accept;
  logic             hold;
  logic             in_range;
  bxavg_pkg::item_t req;

  logic [WW-1:0] col_inc;
  logic [HW-1:0] row_inc;
  logic [SW-1:0] cblk_inc;
  logic [SW-1:0] rblk_inc;
  logic [SW-1:0] rrem_inc;
  logic [WW-1:0] out_col_w;
  logic [HW-1:0] out_row_h;

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= bxavg_pkg::RstSrcWidth;
      src_height_q <= bxavg_pkg::RstSrcHeight;
      scale_q      <= bxavg_pkg::RstScale;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bxavg_pkg::CfgSrcWidth:  src_width_q  <= cfg_wdata_i;
        bxavg_pkg::CfgSrcHeight: src_height_q <= cfg_wdata_i;
        bxavg_pkg::CfgScale:     scale_q      <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (src_width_q == '0) begin
      w_c = WW'(1);
    end else if (32'(src_width_q) > MaxWidth) begin
      w_c = WW'(MaxWidth);
    end else begin
      w_c = WW'(src_width_q);
    end
    if (src_height_q == '0) begin
      h_c = HW'(1);
    end else if (32'(src_height_q) > bxavg_pkg::MaxHeight) begin
      h_c = HW'(bxavg_pkg::MaxHeight);
    end else begin
      h_c = src_height_q;
    end
    if (scale_q == '0) begin
      s_c = SW'(1);
    end else if (32'(scale_q) > MaxScale) begin
      s_c = SW'(MaxScale);
    end else begin
      s_c = SW'(scale_q);
    end
  end

  assign sq = bxavg_pkg::SqW'(s_c) * bxavg_pkg::SqW'(s_c);

  // ---------------- geometry sequencer ----------------
  always_comb begin
    seq_d   = seq_q;
    start_d = 1'b0;
    cap_w   = 1'b0;
    cap_h   = 1'b0;
    cap_r   = 1'b0;
    case (seq_q)
      bxavg_pkg::SEQ_IDLE: ;
      bxavg_pkg::SEQ_WIDTH: begin
        if (div_done && !start_q) begin
          cap_w   = 1'b1;
          seq_d   = bxavg_pkg::SEQ_HEIGHT;
          start_d = 1'b1;
        end
      end
      bxavg_pkg::SEQ_HEIGHT: begin
        if (div_done && !start_q) begin
          cap_h   = 1'b1;
          seq_d   = bxavg_pkg::SEQ_ROW;
          start_d = 1'b1;
        end
      end
      bxavg_pkg::SEQ_ROW: begin
        if (div_done && !start_q) begin
          cap_r = 1'b1;
          seq_d = bxavg_pkg::SEQ_IDLE;
        end
      end
      default: seq_d = bxavg_pkg::SEQ_IDLE;
    endcase
    // a register write restarts the whole pass
    if (cfg_we_i) begin
      seq_d   = bxavg_pkg::SEQ_WIDTH;
      start_d = 1'b1;
      cap_w   = 1'b0;
      cap_h   = 1'b0;
      cap_r   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q   <= bxavg_pkg::SEQ_WIDTH;
      start_q <= 1'b1;
    end else begin
      seq_q   <= seq_d;
      start_q <= start_d;
    end
  end

  assign busy = (seq_q != bxavg_pkg::SEQ_IDLE);

  always_comb begin
    case (seq_q)
      bxavg_pkg::SEQ_WIDTH:  div_dvd = DW'(w_c);
      bxavg_pkg::SEQ_HEIGHT: div_dvd = DW'(h_c);
      default:               div_dvd = DW'(src_row_q);
    endcase
  end

  bxavg_div #(
    .DW (DW),
    .SW (SW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_q),
    .dividend_i  (div_dvd),
    .divisor_i   (s_c),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  always_ff @(posedge clk_i) begin
    if (cap_w) begin
      new_w_q <= WW'(div_quo);
    end
    if (cap_h) begin
      new_h_q <= HW'(div_quo);
    end
  end

  // ---------------- per-pixel control ----------------
  assign in_stall_o = busy || hold;
  assign accept     = in_valid_i && !in_stall_o;

  assign col_inc   = WW'(src_col_q) + WW'(1);
  assign row_inc   = HW'(src_row_q) + HW'(1);
  assign cblk_inc  = SW'(col_blk_q) + SW'(1);
  assign rblk_inc  = SW'(row_blk_q) + SW'(1);
  assign rrem_inc  = SW'(row_rem_q) + SW'(1);
  assign out_col_w = WW'(out_col_q);
  assign out_row_h = HW'(out_row_q);

  assign in_range = (out_col_w < new_w_q) && (out_row_h < new_h_q);

  always_comb begin
    req.pix       = pixel_in_i;
    req.first     = (row_blk_q == '0) && (col_blk_q == '0);
    req.emit      = in_range && (rblk_inc >= s_c) && (cblk_inc >= s_c);
    req.row_end   = (out_col_w + WW'(1)) == new_w_q;
    req.image_end = req.row_end && ((out_row_h + HW'(1)) == new_h_q);
    req.sq        = sq;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_col_q <= '0;
      src_row_q <= '0;
      col_blk_q <= '0;
      row_blk_q <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      row_rem_q <= '0;
    end else if (cap_r) begin
      out_row_q <= RW'(div_quo);
      row_rem_q <= BW'(div_rem);
    end else if (accept) begin
      if (col_inc >= w_c) begin
        src_col_q <= '0;
        col_blk_q <= '0;
        out_col_q <= '0;
        if (row_inc >= h_c) begin
          src_row_q <= '0;
          row_blk_q <= '0;
          out_row_q <= '0;
          row_rem_q <= '0;
        end else begin
          src_row_q <= src_row_q + RW'(1);
          row_blk_q <= (rblk_inc >= s_c) ? '0 : row_blk_q + BW'(1);
          // keep the output row equal to source row over scale
          if (rrem_inc >= s_c) begin
            row_rem_q <= '0;
            out_row_q <= out_row_q + RW'(1);
          end else begin
            row_rem_q <= row_rem_q + BW'(1);
          end
        end
      end else begin
        src_col_q <= src_col_q + CW'(1);
        if (cblk_inc >= s_c) begin
          col_blk_q <= '0;
          out_col_q <= out_col_q + CW'(1);
        end else begin
          col_blk_q <= col_blk_q + BW'(1);
        end
      end
    end
  end

  // ---------------- sum store and output ----------------
  bxavg_accum #(
    .Depth (MaxWidth),
    .AddrW (CW)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (accept && in_range),
    .req_i       (req),
    .idx_i       (out_col_q),
    .hold_o      (hold),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pixel_out_o (pixel_out_o),
    .row_end_o   (row_end_o),
    .image_end_o (image_end_o)
  );

endmodule
